### rtl/nlm_pkg.sv
`default_nettype none

package nlm_pkg;

    // Configuration register indexes
    localparam logic [1:0] CFG_ATTACK  = 2'd0;
    localparam logic [1:0] CFG_RELEASE = 2'd1;
    localparam logic [1:0] CFG_HOLD    = 2'd2;

    localparam logic [15:0] ATTACK_RESET  = 16'd1500;
    localparam logic [15:0] RELEASE_RESET = 16'd250;
    localparam logic [15:0] HOLD_RESET    = 16'd1500;

    // Input tdata layout, lowest bit first
    localparam int IN_EN_LSB     = 0;
    localparam int IN_SND_LSB    = 1;
    localparam int IN_SEQ_LSB    = 2;
    localparam int IN_VEL_LSB    = 34;
    localparam int IN_STEREO_LSB = 41;
    localparam int IN_GL_LSB     = 42;
    localparam int IN_GR_LSB     = 58;
    localparam int IN_NOW_LSB    = 74;
    localparam int IN_TDATA_W    = 112;
    localparam int OUT_TDATA_W   = 40;

    localparam logic [3:0]  NO_PEAK   = 4'd15;
    localparam logic [16:0] MONO_GAIN = 17'h1_0000;
    localparam logic [48:0] ROUND_HALF = 49'h0_8000_0000;
    localparam logic [8:0]  ALPHA_TWICE = 9'd510;

    // velocity*65535/127 = velocity*516 + (3*velocity + 63)/127
    localparam logic [15:0] PK_MUL  = 16'd516;
    localparam logic [8:0]  PK_BIAS = 9'd63;
    localparam logic [8:0]  PK_DIV  = 9'd127;

    localparam int DIV_STEPS = 16;
    localparam int CNT_W     = 4;

    typedef enum logic [1:0] {
        ALU_NOP,
        ALU_MUL,
        ALU_LOAD,
        ALU_STEP
    } t_alu_op;

    typedef struct packed {
        t_alu_op     op;
        logic [31:0] opa;
        logic [16:0] opb;
    } t_alu_cmd;

    typedef enum logic [3:0] {
        S_IDLE,
        S_EVENT,
        S_DMUL,
        S_DLOAD,
        S_DSTEP,
        S_DSTORE,
        S_PEAK,
        S_ALOAD,
        S_ASTEP,
        S_ASTORE,
        S_CMUL1,
        S_CMUL2,
        S_CRND,
        S_DONE
    } t_state;

endpackage

`default_nettype wire

### rtl/note_level_meter_led_bar_unit.sv
`default_nettype none

// Channel   Dir  Handshake                       Contents
// s_axis    in   s_axis_tvalid / s_axis_tready   one display update
// m_axis    out  m_axis_tvalid / m_axis_tready   level, bar counts, peak LEDs, glow
// cfg       in   i_cfg_we (no wait)              fall and hold times
//
// From accept to the next accept, an enabled item runs up to two 16-step
// divisions (decay level, peak glow) plus eight multiplies for the columns,
// all through the one shared multiply/divide unit. Skipped divisions shorten
// the run; a disabled item goes straight to done. Synchronous active-low reset
// restores the register defaults and clears the meter state. A stalled result
// waits in the output register; the next item is taken meanwhile and waits in
// its last state.
module note_level_meter_led_bar_unit #(
    parameter int SEGMENTS = 14
) (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         s_axis_tvalid,
    output logic              s_axis_tready,
    // [0] channel_enabled, [1] sounding, [33:2] note_on_sequence,
    // [40:34] velocity, [41] is_stereo, [57:42] gain_left,
    // [73:58] gain_right, [105:74] time_now, [111:106] zero
    input  wire logic [nlm_pkg::IN_TDATA_W-1:0] s_axis_tdata,
    output logic              m_axis_tvalid,
    input  wire logic         m_axis_tready,
    // [15:0] level_value, [19:16] lit_left, [23:20] peak_seg_left,
    // [27:24] lit_right, [31:28] peak_seg_right, [39:32] peak_alpha
    output logic [nlm_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
    input  wire logic         i_cfg_we,
    input  wire logic [1:0]   i_cfg_idx,
    input  wire logic [15:0]  i_cfg_wdata
);

    localparam int SEG_W = $clog2(SEGMENTS + 1);

    // configuration
    logic [15:0] r_attack, r_release, r_hold;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_attack  <= nlm_pkg::ATTACK_RESET;
            r_release <= nlm_pkg::RELEASE_RESET;
            r_hold    <= nlm_pkg::HOLD_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                nlm_pkg::CFG_ATTACK:  r_attack  <= i_cfg_wdata;
                nlm_pkg::CFG_RELEASE: r_release <= i_cfg_wdata;
                nlm_pkg::CFG_HOLD:    r_hold    <= i_cfg_wdata;
                default: begin
                end
            endcase
        end
    end

    // latched item
    logic        r_blank, r_snd, r_stereo;
    logic [31:0] r_seq, r_now;
    logic [6:0]  r_vel;
    logic [15:0] r_gl, r_gr;

    logic w_accept;
    assign w_accept = s_axis_tvalid && s_axis_tready;

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_blank  <= !s_axis_tdata[nlm_pkg::IN_EN_LSB];
            r_snd    <= s_axis_tdata[nlm_pkg::IN_SND_LSB];
            r_seq    <= s_axis_tdata[nlm_pkg::IN_SEQ_LSB +: 32];
            r_vel    <= s_axis_tdata[nlm_pkg::IN_VEL_LSB +: 7];
            r_stereo <= s_axis_tdata[nlm_pkg::IN_STEREO_LSB];
            r_gl     <= s_axis_tdata[nlm_pkg::IN_GL_LSB +: 16];
            r_gr     <= s_axis_tdata[nlm_pkg::IN_GR_LSB +: 16];
            r_now    <= s_axis_tdata[nlm_pkg::IN_NOW_LSB +: 32];
        end
    end

    // sequencer and meter state
    nlm_pkg::t_state r_state, n_state;
    logic [nlm_pkg::CNT_W-1:0] r_cnt, n_cnt;
    logic [1:0]  r_col, n_col;
    logic        r_prev_snd, n_prev_snd;
    logic [31:0] r_prev_seq, n_prev_seq;
    logic [15:0] r_origin, n_origin;
    logic [31:0] r_dec_start, n_dec_start;
    logic        r_dec_run, n_dec_run;
    logic        r_dec_rel, n_dec_rel;
    logic [15:0] r_level, n_level;
    logic [15:0] r_peak, n_peak;
    logic [31:0] r_peak_start, n_peak_start;
    logic        r_peak_run, n_peak_run;
    logic [7:0]  r_alpha, n_alpha;
    logic        r_glow, n_glow;
    logic        r_pnz, n_pnz;
    logic [3:0]  r_lit_l, n_lit_l, r_pseg_l, n_pseg_l;
    logic [3:0]  r_lit_r, n_lit_r, r_pseg_r, n_pseg_r;
    logic        r_out_valid, n_out_valid;
    logic [39:0] r_out_data, n_out_data;

    nlm_pkg::t_alu_cmd w_cmd;
    logic [48:0] w_prod;
    logic [15:0] w_quo;

    nlm_alu u_alu (
        .i_clk  (i_clk),
        .i_cmd  (w_cmd),
        .o_prod (w_prod),
        .o_quo  (w_quo)
    );

    // note-on level from velocity
    logic [8:0]  w_pk_t;
    logic [15:0] w_pk;
    always_comb begin
        w_pk_t = 9'(r_vel) + 9'(r_vel) + 9'(r_vel) + nlm_pkg::PK_BIAS;
        w_pk   = 16'({9'd0, r_vel} * nlm_pkg::PK_MUL);
        if (w_pk_t >= 9'(3 * nlm_pkg::PK_DIV)) begin
            w_pk = w_pk + 16'd3;
        end else if (w_pk_t >= 9'(2 * nlm_pkg::PK_DIV)) begin
            w_pk = w_pk + 16'd2;
        end else if (w_pk_t >= nlm_pkg::PK_DIV) begin
            w_pk = w_pk + 16'd1;
        end
    end

    logic        w_note_on, w_note_off;
    logic [15:0] w_dec_d;
    logic [31:0] w_dec_e, w_pk_e;
    logic        w_dec_hit, w_glow_now;
    logic [16:0] w_gain_l, w_gain_r;
    logic [48:0] w_rnd_sum;
    logic [SEG_W-1:0] w_rnd, w_rm1;
    logic [3:0]  w_pseg;

    assign w_note_on  = r_snd && (r_seq != r_prev_seq);
    assign w_note_off = !r_snd && r_prev_snd;
    assign w_dec_d    = r_dec_rel ? r_release : r_attack;
    assign w_dec_e    = r_now - r_dec_start;
    assign w_dec_hit  = w_dec_e >= {16'd0, w_dec_d};
    assign w_pk_e     = r_now - r_peak_start;
    assign w_glow_now = r_peak_run && (w_pk_e < {16'd0, r_hold});
    assign w_gain_l   = r_stereo ? {1'b0, r_gl} : nlm_pkg::MONO_GAIN;
    assign w_gain_r   = r_stereo ? {1'b0, r_gr} : nlm_pkg::MONO_GAIN;
    assign w_rnd_sum  = w_prod + nlm_pkg::ROUND_HALF;
    assign w_rnd      = w_rnd_sum[32 +: SEG_W];

    always_comb begin
        w_rm1 = (w_rnd == '0) ? '0 : w_rnd - 1'b1;
        if (w_rm1 > SEG_W'(SEGMENTS - 1)) begin
            w_rm1 = SEG_W'(SEGMENTS - 1);
        end
        w_pseg = (r_pnz && r_glow) ? 4'(w_rm1) : nlm_pkg::NO_PEAK;
    end

    always_comb begin
        n_state      = r_state;
        n_cnt        = r_cnt;
        n_col        = r_col;
        n_prev_snd   = r_prev_snd;
        n_prev_seq   = r_prev_seq;
        n_origin     = r_origin;
        n_dec_start  = r_dec_start;
        n_dec_run    = r_dec_run;
        n_dec_rel    = r_dec_rel;
        n_level      = r_level;
        n_peak       = r_peak;
        n_peak_start = r_peak_start;
        n_peak_run   = r_peak_run;
        n_alpha      = r_alpha;
        n_glow       = r_glow;
        n_pnz        = r_pnz;
        n_lit_l      = r_lit_l;
        n_pseg_l     = r_pseg_l;
        n_lit_r      = r_lit_r;
        n_pseg_r     = r_pseg_r;
        n_out_valid  = r_out_valid && !m_axis_tready;
        n_out_data   = r_out_data;
        w_cmd.op     = nlm_pkg::ALU_NOP;
        w_cmd.opa    = '0;
        w_cmd.opb    = '0;
        s_axis_tready = 1'b0;

        case (r_state)
            nlm_pkg::S_IDLE: begin
                s_axis_tready = 1'b1;
                if (s_axis_tvalid) begin
                    n_state = s_axis_tdata[nlm_pkg::IN_EN_LSB] ? nlm_pkg::S_EVENT
                                                               : nlm_pkg::S_DONE;
                end
            end
            nlm_pkg::S_EVENT: begin
                if (w_note_on) begin
                    n_origin     = w_pk;
                    n_dec_start  = r_now;
                    n_dec_run    = 1'b1;
                    n_dec_rel    = 1'b0;
                    n_level      = w_pk;
                    n_peak       = w_pk;
                    n_peak_start = r_now;
                    n_peak_run   = 1'b1;
                end else if (w_note_off) begin
                    n_origin    = r_level;
                    n_dec_start = r_now;
                    n_dec_run   = 1'b1;
                    n_dec_rel   = 1'b1;
                    n_peak      = '0;
                    n_peak_run  = 1'b0;
                end
                n_prev_snd = r_snd;
                n_prev_seq = r_seq;
                n_state    = nlm_pkg::S_DMUL;
            end
            nlm_pkg::S_DMUL: begin
                if (!r_dec_run) begin
                    n_state = nlm_pkg::S_PEAK;
                end else if (w_dec_hit) begin
                    n_level = '0;
                    n_state = nlm_pkg::S_PEAK;
                end else begin
                    w_cmd.op  = nlm_pkg::ALU_MUL;
                    w_cmd.opa = {16'd0, r_origin};
                    w_cmd.opb = {1'b0, w_dec_d - w_dec_e[15:0]};
                    n_state   = nlm_pkg::S_DLOAD;
                end
            end
            nlm_pkg::S_DLOAD: begin
                w_cmd.op  = nlm_pkg::ALU_LOAD;
                w_cmd.opa = w_prod[31:0];
                w_cmd.opb = {1'b0, w_dec_d};
                n_cnt     = '0;
                n_state   = nlm_pkg::S_DSTEP;
            end
            nlm_pkg::S_DSTEP: begin
                w_cmd.op = nlm_pkg::ALU_STEP;
                n_cnt    = r_cnt + 1'b1;
                if (r_cnt == nlm_pkg::CNT_W'(nlm_pkg::DIV_STEPS - 1)) begin
                    n_state = nlm_pkg::S_DSTORE;
                end
            end
            nlm_pkg::S_DSTORE: begin
                n_level = w_quo;
                n_state = nlm_pkg::S_PEAK;
            end
            nlm_pkg::S_PEAK: begin
                n_glow  = w_glow_now;
                n_alpha = '0;
                if (w_glow_now) begin
                    w_cmd.op  = nlm_pkg::ALU_MUL;
                    w_cmd.opa = {16'd0, r_hold - w_pk_e[15:0]};
                    w_cmd.opb = 17'(nlm_pkg::ALPHA_TWICE);
                    n_state   = nlm_pkg::S_ALOAD;
                end else begin
                    n_col   = '0;
                    n_state = nlm_pkg::S_CMUL1;
                end
            end
            nlm_pkg::S_ALOAD: begin
                // round half up: (510*(h-e) + h) / 2h
                w_cmd.op  = nlm_pkg::ALU_LOAD;
                w_cmd.opa = w_prod[31:0] + {16'd0, r_hold};
                w_cmd.opb = {r_hold, 1'b0};
                n_cnt     = '0;
                n_state   = nlm_pkg::S_ASTEP;
            end
            nlm_pkg::S_ASTEP: begin
                w_cmd.op = nlm_pkg::ALU_STEP;
                n_cnt    = r_cnt + 1'b1;
                if (r_cnt == nlm_pkg::CNT_W'(nlm_pkg::DIV_STEPS - 1)) begin
                    n_state = nlm_pkg::S_ASTORE;
                end
            end
            nlm_pkg::S_ASTORE: begin
                n_alpha = (w_quo[15:8] != 8'd0) ? 8'hFF : w_quo[7:0];
                n_col   = '0;
                n_state = nlm_pkg::S_CMUL1;
            end
            nlm_pkg::S_CMUL1: begin
                // column order: left lit, left peak, right lit, right peak
                w_cmd.op  = nlm_pkg::ALU_MUL;
                w_cmd.opa = {16'd0, r_col[0] ? r_peak : r_level};
                w_cmd.opb = r_col[1] ? w_gain_r : w_gain_l;
                n_state   = nlm_pkg::S_CMUL2;
            end
            nlm_pkg::S_CMUL2: begin
                w_cmd.op  = nlm_pkg::ALU_MUL;
                w_cmd.opa = w_prod[31:0];
                w_cmd.opb = 17'(SEGMENTS);
                n_pnz     = w_prod[31:0] != 32'd0;
                n_state   = nlm_pkg::S_CRND;
            end
            nlm_pkg::S_CRND: begin
                if (!r_col[1] && !r_col[0]) n_lit_l  = 4'(w_rnd);
                if (!r_col[1] &&  r_col[0]) n_pseg_l = w_pseg;
                if ( r_col[1] && !r_col[0]) n_lit_r  = 4'(w_rnd);
                if ( r_col[1] &&  r_col[0]) n_pseg_r = w_pseg;
                n_col   = r_col + 1'b1;
                n_state = (r_col == 2'd3) ? nlm_pkg::S_DONE : nlm_pkg::S_CMUL1;
            end
            nlm_pkg::S_DONE: begin
                // hold until the output register frees up
                if (!r_out_valid || m_axis_tready) begin
                    n_out_valid = 1'b1;
                    if (r_blank) begin
                        n_out_data = {8'd0, nlm_pkg::NO_PEAK, 4'd0,
                                      nlm_pkg::NO_PEAK, 4'd0, 16'd0};
                    end else begin
                        n_out_data = {r_alpha, r_pseg_r, r_lit_r,
                                      r_pseg_l, r_lit_l, r_level};
                    end
                    n_state = nlm_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = nlm_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= nlm_pkg::S_IDLE;
            r_cnt        <= '0;
            r_col        <= '0;
            r_prev_snd   <= 1'b0;
            r_prev_seq   <= '0;
            r_origin     <= '0;
            r_dec_start  <= '0;
            r_dec_run    <= 1'b0;
            r_dec_rel    <= 1'b0;
            r_level      <= '0;
            r_peak       <= '0;
            r_peak_start <= '0;
            r_peak_run   <= 1'b0;
            r_alpha      <= '0;
            r_glow       <= 1'b0;
            r_pnz        <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_cnt        <= n_cnt;
            r_col        <= n_col;
            r_prev_snd   <= n_prev_snd;
            r_prev_seq   <= n_prev_seq;
            r_origin     <= n_origin;
            r_dec_start  <= n_dec_start;
            r_dec_run    <= n_dec_run;
            r_dec_rel    <= n_dec_rel;
            r_level      <= n_level;
            r_peak       <= n_peak;
            r_peak_start <= n_peak_start;
            r_peak_run   <= n_peak_run;
            r_alpha      <= n_alpha;
            r_glow       <= n_glow;
            r_pnz        <= n_pnz;
            r_out_valid  <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_lit_l    <= n_lit_l;
        r_pseg_l   <= n_pseg_l;
        r_lit_r    <= n_lit_r;
        r_pseg_r   <= n_pseg_r;
        r_out_data <= n_out_data;
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;

    a_accept_drops_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
        else $error("ready stayed high after an accepted item");

    a_level_below_origin: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_level <= r_origin)
        else $error("decay level above its starting point");

    a_alpha_needs_glow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_alpha != 8'd0) |-> r_glow)
        else $error("peak alpha set without a running glow");

    a_out_only_from_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != nlm_pkg::S_DONE && !r_out_valid) |=> !r_out_valid)
        else $error("result raised outside the done state");

endmodule

`default_nettype wire

### rtl/nlm_alu.sv
`default_nettype none

// Shared arithmetic unit: one registered 32x17 multiply, or one restoring
// division step per cycle. A load expects numerator[31:16] below the divisor,
// so sixteen steps leave the quotient in o_quo.
module nlm_alu (
    input  wire logic              i_clk,
    input  wire nlm_pkg::t_alu_cmd i_cmd,
    output logic [48:0]            o_prod,
    output logic [15:0]            o_quo
);

    logic [48:0] r_prod;
    logic [16:0] r_rem;
    logic [15:0] r_quo;
    logic [16:0] r_dvs;

    logic [48:0] w_mul;
    logic [18:0] w_trial;
    logic        w_ge;

    assign w_mul   = {17'd0, i_cmd.opa} * {32'd0, i_cmd.opb};
    assign w_trial = {1'b0, r_rem, r_quo[15]} - {2'b00, r_dvs};
    assign w_ge    = !w_trial[18];

    always_ff @(posedge i_clk) begin
        case (i_cmd.op)
            nlm_pkg::ALU_MUL: begin
                r_prod <= w_mul;
            end
            nlm_pkg::ALU_LOAD: begin
                r_rem <= {1'b0, i_cmd.opa[31:16]};
                r_quo <= i_cmd.opa[15:0];
                r_dvs <= i_cmd.opb;
            end
            nlm_pkg::ALU_STEP: begin
                r_rem <= w_ge ? w_trial[16:0] : {r_rem[15:0], r_quo[15]};
                r_quo <= {r_quo[14:0], w_ge};
            end
            default: begin
            end
        endcase
    end

    assign o_prod = r_prod;
    assign o_quo  = r_quo;

endmodule

`default_nettype wire
